// ===== rtl/plist_pkg.sv =====
// Shared types and constants for the positional list block.
`default_nettype none

package plist_pkg;

    // Default sizing of the list store.
    localparam int DEPTH_DEF     = 32;
    localparam int WORD_BITS_DEF = 32;

    // Width of positions and counts inside the cell chain (covers DEPTH up to 64).
    localparam int CTL_POS_W = 7;

    // Request commands.
    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_DELETE  = 2'd1,
        CMD_REVERSE = 2'd2,
        CMD_DUMP    = 2'd3
    } cmd_t;

    // Per-cycle operation broadcast to every cell.
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2,
        CELL_ROTATE = 2'd3
    } cell_op_t;

    // Cell control: operation plus the position it refers to.
    typedef struct packed {
        cell_op_t               op;
        logic [CTL_POS_W-1:0]   pos;
    } cell_ctl_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_REVERSE = 2'd1,
        ST_DUMP    = 2'd2
    } state_t;

    // Input request payload.
    typedef struct packed {
        cmd_t               command;
        logic [5:0]         position;
        logic signed [31:0] value;
    } in_req_t;

    // Result payload.
    typedef struct packed {
        logic               ok;
        logic               has_element;
        logic signed [31:0] element;
        logic               last;
        logic [5:0]         count;
    } out_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/plist_cell.sv =====
// One storage cell of the list chain: holds a word and shifts with its neighbors.
`default_nettype none

module plist_cell #(
    parameter int INDEX     = 0,
    parameter int WORD_BITS = plist_pkg::WORD_BITS_DEF
) (
    input  wire                         aclk,
    input  plist_pkg::cell_ctl_t        ctl,
    input  wire [WORD_BITS-1:0]         left_word,
    input  wire [WORD_BITS-1:0]         right_word,
    input  wire [WORD_BITS-1:0]         head_word,
    input  wire [WORD_BITS-1:0]         wr_word,
    output logic [WORD_BITS-1:0]        word
);
    import plist_pkg::*;

    localparam logic [CTL_POS_W-1:0] MY_IDX = CTL_POS_W'(INDEX);

    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;

    // Select the new contents from neighbors or broadcasts.
    always_comb begin
        word_next = word_reg;
        unique case (ctl.op)
            CELL_INSERT: begin
                if (MY_IDX > ctl.pos) begin
                    word_next = left_word;
                end else if (MY_IDX == ctl.pos) begin
                    word_next = wr_word;
                end
            end
            CELL_DELETE: begin
                if (MY_IDX >= ctl.pos) begin
                    word_next = right_word;
                end
            end
            CELL_ROTATE: begin
                // rotate left over [0, pos]; head word wraps to the end
                if (MY_IDX < ctl.pos) begin
                    word_next = right_word;
                end else if (MY_IDX == ctl.pos) begin
                    word_next = head_word;
                end
            end
            default: begin
                word_next = word_reg;
            end
        endcase
    end

    // Data register, no reset: contents are only read below the count.
    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

`default_nettype wire

// ===== rtl/positional_list_insert_delete_reverse.sv =====
// Top level of the positional list: sequencer, output register and cell chain.
//
// Usage: requests enter on s_valid/s_ready with s_data (command, position,
// value); results leave on m_valid/m_ready with m_data. Each request gives
// one result, except a dump of a non-empty list, which gives one result per
// entry in list order with last set on the tail entry.
// Insert and delete: the chain shifts in the cycle the request
// is accepted and the result sits in the output register the next cycle, so
// a new request can be taken every cycle while the receiver keeps up.
// Reverse: the chain rotates a shrinking prefix left, one rotation per cycle;
// its result is issued at acceptance.
// Dump gives one result per entry: the chain rotates the whole list
// left by one each time a result is loaded, ending in its original order.
// When the receiver stalls, the result holds in the output register and the
// dump sequencer pauses; a new request is taken only while idle with the
// output register free or being drained.
// Reset (aresetn low, synchronous) empties the list and drops any pending
// result; the cell contents are not cleared and are never read unwritten.
`default_nettype none

module positional_list_insert_delete_reverse #(
    parameter int DEPTH     = plist_pkg::DEPTH_DEF,
    parameter int WORD_BITS = plist_pkg::WORD_BITS_DEF
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  plist_pkg::in_req_t  s_data,
    output logic                m_valid,
    input  wire                 m_ready,
    output plist_pkg::out_rsp_t m_data
);
    import plist_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CTL_POS_W-1:0] DEPTH_W = CTL_POS_W'(DEPTH);

    // Cell chain wiring.
    logic [WORD_BITS-1:0] cell_word [DEPTH];
    logic [WORD_BITS-1:0] head_word;
    logic [WORD_BITS-1:0] wr_word;
    logic [63:0]          value_sext;
    logic [63:0]          head_ext;
    cell_ctl_t            ctl;

    // Control and output registers.
    state_t               state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CTL_POS_W-1:0] lim_reg, lim_next;
    logic [CTL_POS_W-1:0] step_reg, step_next;
    logic                 m_valid_reg, m_valid_next;
    out_rsp_t             m_data_reg, m_data_next;

    logic [CTL_POS_W-1:0] count_w;
    logic [CTL_POS_W-1:0] pos_w;
    logic [CTL_POS_W-1:0] cnt_out;
    logic                 out_free;
    logic                 out_load;
    logic                 dump_last;

    assign count_w  = CTL_POS_W'(count_reg);
    assign pos_w    = CTL_POS_W'(s_data.position);
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;

    // Stored word is the sign-extended value cut to the word width.
    assign value_sext = {{32{s_data.value[31]}}, s_data.value};
    assign wr_word    = value_sext[WORD_BITS-1:0];
    assign head_word  = cell_word[0];
    assign head_ext   = 64'(head_word);
    assign dump_last  = (step_reg == (count_w - CTL_POS_W'(1)));

    // Chain of cells, each wired to its neighbors; an end cell reads its own word.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [WORD_BITS-1:0] left_w;
        logic [WORD_BITS-1:0] right_w;
        if (i == 0) begin : g_first
            assign left_w = cell_word[i];
        end else begin : g_mid_l
            assign left_w = cell_word[i-1];
        end
        if (i == DEPTH - 1) begin : g_end
            assign right_w = cell_word[i];
        end else begin : g_mid_r
            assign right_w = cell_word[i+1];
        end
        plist_cell #(
            .INDEX     (i),
            .WORD_BITS (WORD_BITS)
        ) u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .left_word  (left_w),
            .right_word (right_w),
            .head_word  (head_word),
            .wr_word    (wr_word),
            .word       (cell_word[i])
        );
    end

    // Sequencer: next state, cell control and result formation.
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        lim_next    = lim_reg;
        step_next   = step_reg;
        ctl.op      = CELL_HOLD;
        ctl.pos     = '0;
        out_load    = 1'b0;
        m_data_next = m_data_reg;
        cnt_out     = count_w;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    out_load    = 1'b1;
                    m_data_next = '0;
                    unique case (s_data.command)
                        CMD_INSERT: begin
                            if (pos_w <= count_w && count_w < DEPTH_W) begin
                                ctl.op      = CELL_INSERT;
                                ctl.pos     = pos_w;
                                count_next  = CW'(count_w + CTL_POS_W'(1));
                                cnt_out     = count_w + CTL_POS_W'(1);
                                m_data_next.ok = 1'b1;
                            end
                        end
                        CMD_DELETE: begin
                            if (count_w != '0 && pos_w < count_w) begin
                                ctl.op      = CELL_DELETE;
                                ctl.pos     = pos_w;
                                count_next  = CW'(count_w - CTL_POS_W'(1));
                                cnt_out     = count_w - CTL_POS_W'(1);
                                m_data_next.ok = 1'b1;
                            end
                        end
                        CMD_REVERSE: begin
                            if (count_w != '0) begin
                                m_data_next.ok = 1'b1;
                            end
                            if (count_w > CTL_POS_W'(1)) begin
                                state_next = ST_REVERSE;
                                lim_next   = count_w - CTL_POS_W'(1);
                            end
                        end
                        CMD_DUMP: begin
                            if (count_w != '0) begin
                                out_load   = 1'b0;
                                state_next = ST_DUMP;
                                step_next  = '0;
                            end
                        end
                        default: begin
                            out_load = 1'b1;
                        end
                    endcase
                    m_data_next.last  = 1'b1;
                    m_data_next.count = cnt_out[5:0];
                end
            end
            ST_REVERSE: begin
                // rotate prefix [0, lim] left; the old head lands at lim
                ctl.op   = CELL_ROTATE;
                ctl.pos  = lim_reg;
                lim_next = lim_reg - CTL_POS_W'(1);
                if (lim_reg == CTL_POS_W'(1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_DUMP: begin
                if (out_free) begin
                    out_load                = 1'b1;
                    m_data_next.ok          = 1'b1;
                    m_data_next.has_element = 1'b1;
                    m_data_next.element     = head_ext[31:0];
                    m_data_next.last        = dump_last;
                    m_data_next.count       = count_w[5:0];
                    ctl.op                  = CELL_ROTATE;
                    ctl.pos                 = count_w - CTL_POS_W'(1);
                    step_next               = step_reg + CTL_POS_W'(1);
                    if (dump_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set on load, cleared when taken.
    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Sequencer counters and result payload.
    always_ff @(posedge aclk) begin
        lim_reg    <= lim_next;
        step_reg   <= step_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    // The count never goes past the store depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_w <= DEPTH_W)
        else $error("entry count exceeds depth");

    // Requests are taken only while the sequencer is idle.
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == ST_IDLE)
        else $error("ready while sequencer busy");

    // Reverse and dump never change the entry count.
    a_count_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |=> $stable(count_reg))
        else $error("count changed during reverse or dump");

    // A dumped entry always reports success.
    a_elem_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.has_element |-> m_data.ok)
        else $error("dumped entry without ok");

    // Reverse runs with a prefix limit of at least one.
    a_rev_lim: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_REVERSE |-> lim_reg != '0)
        else $error("reverse limit reached zero");
`endif

endmodule

`default_nettype wire
